// ----- rtl/rv_isel_pkg.sv -----
// shared constants, word types and the global mask function for the interrupt selector
package rv_isel_pkg;

    localparam int unsigned LOCAL_COUNT  = 48;
    localparam int unsigned LOCAL_BASE   = 16;
    localparam int unsigned LOCAL_GROUPS = LOCAL_COUNT / 8;

    localparam int unsigned B_SSI  = 1;
    localparam int unsigned B_VSSI = 2;
    localparam int unsigned B_MSI  = 3;
    localparam int unsigned B_STI  = 5;
    localparam int unsigned B_VSTI = 6;
    localparam int unsigned B_MTI  = 7;
    localparam int unsigned B_SEI  = 9;
    localparam int unsigned B_VSEI = 10;
    localparam int unsigned B_MEI  = 11;
    localparam int unsigned B_SGEI = 12;

    localparam logic [63:0] LOCAL_MASK  = 64'hFFFF_FFFF_FFFF_0000;
    localparam logic [63:0] M_GROUP  = (64'd1 << B_MEI) | (64'd1 << B_MTI) | (64'd1 << B_MSI);
    localparam logic [63:0] S_GROUP  = (64'd1 << B_SEI) | (64'd1 << B_STI) | (64'd1 << B_SSI);
    localparam logic [63:0] VS_GROUP = (64'd1 << B_VSEI) | (64'd1 << B_VSSI) | (64'd1 << B_VSTI);
    // narrow order: locals 15..0 plus the machine and supervisor sources only
    localparam logic [63:0] NARROW_MASK = 64'h0000_0000_FFFF_0000 | M_GROUP | S_GROUP;

    // privilege codes
    localparam logic [1:0] PRV_U   = 2'd0;
    localparam logic [1:0] PRV_S   = 2'd1;
    localparam logic [1:0] PRV_BAD = 2'd2;
    localparam logic [1:0] PRV_M   = 2'd3;

    // register indexes
    localparam logic [2:0] REG_MDELEG = 3'd0;
    localparam logic [2:0] REG_HDELEG = 3'd1;
    localparam logic [2:0] REG_HAS_S  = 3'd2;
    localparam logic [2:0] REG_HAS_H  = 3'd3;
    localparam logic [2:0] REG_WIDE   = 3'd4;
    localparam logic [2:0] REG_NMI    = 3'd5;

    typedef struct packed {
        logic        pad;
        logic        nmi_pending;
        logic [63:0] enable_bits;
        logic [63:0] pending_bits;
        logic        vsuper_ie;
        logic        super_ie;
        logic        machine_ie;
        logic        virt_on;
        logic [1:0]  privilege;
    } t_in_word;

    typedef struct packed {
        logic [4:0] pad;
        logic       bad_mode;
        logic [7:0] cause;
        logic       is_nmi;
        logic       taken;
    } t_out_word;

    function automatic logic [63:0] global_mask(
        input logic [1:0]  prv,
        input logic        virt,
        input logic        mie,
        input logic        sie,
        input logic        vsie,
        input logic [63:0] md,
        input logic [63:0] hd,
        input logic        has_h
    );
        logic [63:0] both;
        logic [63:0] m;
        logic [63:0] loc;
        logic [63:0] base;
        logic        v;
        both = md & hd;
        m    = '0;
        v    = has_h & virt;
        case (prv)
            PRV_U, PRV_S: begin
                if (v) begin
                    loc = (prv == PRV_S && sie) ? '1 : ~both;
                    m   = (loc & LOCAL_MASK)
                        | ((vsie ? '1 : ~hd) & VS_GROUP)
                        | ((vsie ? '1 : ~both) & (M_GROUP | S_GROUP));
                end else if (prv == PRV_U) begin
                    m = LOCAL_MASK | M_GROUP | S_GROUP;
                end else begin
                    base = sie ? '1 : ~md;
                    m    = (base & (LOCAL_MASK | M_GROUP)) | (sie ? S_GROUP : '0);
                end
            end
            PRV_M: begin
                m = mie ? (LOCAL_MASK | M_GROUP) : '0;
            end
            default: begin
                m = '0;
            end
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/riscv_interrupt_select_top.sv -----
// top level of the interrupt selector: input register, selection logic, result register
// each word passes the input register and then the result register to the master side
// throughput: one word per cycle; the input register feeds the result register directly
// a full result register stalls the input register only while the master side holds tready low
// reset (synchronous, active low) empties both registers and loads the register defaults
// config defaults: delegations zero, supervisor present, no hypervisor, wide order, nmi cause 0
module riscv_interrupt_select_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // privilege[1:0], virt_on[2], machine_ie[3], super_ie[4], vsuper_ie[5],
    // pending_bits[69:6], enable_bits[133:70], nmi_pending[134], zero[135]
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // taken[0], is_nmi[1], cause[9:2], bad_mode[10], zero[15:11]
    output logic [15:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    rv_isel_pkg::t_in_word  r_in;
    rv_isel_pkg::t_out_word r_out;
    rv_isel_pkg::t_out_word n_out;
    logic        r_in_valid;
    logic        r_out_valid;
    logic        w_adv;

    logic [63:0] r_mdeleg;
    logic [63:0] r_hdeleg;
    logic        r_has_s;
    logic        r_has_h;
    logic        r_wide;
    logic [7:0]  r_nmi_code;

    logic        w_cfg_wr;
    logic [2:0]  w_reg_idx;

    logic [63:0] w_mask;
    logic [63:0] w_cand;
    logic [47:0] w_loc;
    logic [rv_isel_pkg::LOCAL_GROUPS-1:0] w_grp_any;
    logic        w_loc_hit;
    logic [2:0]  w_grp;
    logic [7:0]  w_grp_bits;
    logic [2:0]  w_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[5:3];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mdeleg   <= '0;
            r_hdeleg   <= '0;
            r_has_s    <= 1'b1;
            r_has_h    <= 1'b0;
            r_wide     <= 1'b1;
            r_nmi_code <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                rv_isel_pkg::REG_MDELEG: r_mdeleg   <= pwdata;
                rv_isel_pkg::REG_HDELEG: r_hdeleg   <= pwdata;
                rv_isel_pkg::REG_HAS_S:  r_has_s    <= pwdata[0];
                rv_isel_pkg::REG_HAS_H:  r_has_h    <= pwdata[0];
                rv_isel_pkg::REG_WIDE:   r_wide     <= pwdata[0];
                rv_isel_pkg::REG_NMI:    r_nmi_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            rv_isel_pkg::REG_MDELEG: prdata = r_mdeleg;
            rv_isel_pkg::REG_HDELEG: prdata = r_hdeleg;
            rv_isel_pkg::REG_HAS_S:  prdata = {63'd0, r_has_s};
            rv_isel_pkg::REG_HAS_H:  prdata = {63'd0, r_has_h};
            rv_isel_pkg::REG_WIDE:   prdata = {63'd0, r_wide};
            rv_isel_pkg::REG_NMI:    prdata = {56'd0, r_nmi_code};
            default:                 prdata = '0;
        endcase
    end

    // handshake: the input register moves on when the result register is free or drained
    assign w_adv         = ~r_out_valid | m_axis_tready;
    assign s_axis_tready = ~r_in_valid | w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= rv_isel_pkg::t_in_word'(s_axis_tdata);
        end
    end

    // selection
    assign w_mask = rv_isel_pkg::global_mask(r_in.privilege, r_in.virt_on, r_in.machine_ie,
        r_in.super_ie, r_in.vsuper_ie, r_has_s ? r_mdeleg : 64'd0, r_hdeleg, r_has_h);

    // narrow order drops the upper locals and the hypervisor tail
    assign w_cand = r_in.pending_bits & r_in.enable_bits & w_mask
                  & (r_wide ? 64'hFFFF_FFFF_FFFF_FFFF : rv_isel_pkg::NARROW_MASK);
    assign w_loc  = w_cand[63:16];

    always_comb begin
        for (int g = 0; g < rv_isel_pkg::LOCAL_GROUPS; g++) begin
            w_grp_any[g] = |w_loc[g*8 +: 8];
        end
    end

    assign w_loc_hit = |w_grp_any;

    always_comb begin
        w_grp = '0;
        for (int g = 0; g < rv_isel_pkg::LOCAL_GROUPS; g++) begin
            if (w_grp_any[g]) begin
                w_grp = 3'(g);
            end
        end
    end

    assign w_grp_bits = w_loc[{w_grp, 3'b000} +: 8];

    always_comb begin
        w_idx = '0;
        for (int b = 0; b < 8; b++) begin
            if (w_grp_bits[b]) begin
                w_idx = 3'(b);
            end
        end
    end

    always_comb begin
        n_out          = '0;
        n_out.bad_mode = (r_in.privilege == rv_isel_pkg::PRV_BAD);
        if (r_in.nmi_pending) begin
            n_out.taken  = 1'b1;
            n_out.is_nmi = 1'b1;
            n_out.cause  = r_nmi_code;
        end else if (w_loc_hit) begin
            n_out.taken = 1'b1;
            n_out.cause = 8'(rv_isel_pkg::LOCAL_BASE) + {2'b00, w_grp, w_idx};
        end else begin
            n_out.taken = 1'b1;
            if (w_cand[rv_isel_pkg::B_MEI]) begin
                n_out.cause = 8'(rv_isel_pkg::B_MEI);
            end else if (w_cand[rv_isel_pkg::B_MSI]) begin
                n_out.cause = 8'(rv_isel_pkg::B_MSI);
            end else if (w_cand[rv_isel_pkg::B_MTI]) begin
                n_out.cause = 8'(rv_isel_pkg::B_MTI);
            end else if (w_cand[rv_isel_pkg::B_SEI]) begin
                n_out.cause = 8'(rv_isel_pkg::B_SEI);
            end else if (w_cand[rv_isel_pkg::B_SSI]) begin
                n_out.cause = 8'(rv_isel_pkg::B_SSI);
            end else if (w_cand[rv_isel_pkg::B_STI]) begin
                n_out.cause = 8'(rv_isel_pkg::B_STI);
            end else if (w_cand[rv_isel_pkg::B_SGEI]) begin
                n_out.cause = 8'(rv_isel_pkg::B_SGEI);
            end else if (w_cand[rv_isel_pkg::B_VSEI]) begin
                n_out.cause = 8'(rv_isel_pkg::B_VSEI);
            end else if (w_cand[rv_isel_pkg::B_VSSI]) begin
                n_out.cause = 8'(rv_isel_pkg::B_VSSI);
            end else if (w_cand[rv_isel_pkg::B_VSTI]) begin
                n_out.cause = 8'(rv_isel_pkg::B_VSTI);
            end else begin
                n_out.taken = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    a_nmi_implies_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
        else $error("nmi result without taken");

    a_bad_mode_only_nmi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[10] && m_axis_tdata[0]) |-> m_axis_tdata[1])
        else $error("maskable interrupt taken in invalid privilege");

    a_word_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv) |=> r_out_valid)
        else $error("word lost between input and result registers");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

// ----- bench/riscv_interrupt_select_top_tb.sv -----
// self-checking testbench for the interrupt selector: directed table, then random words
module riscv_interrupt_select_top_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PER_SETTING = 134;
    localparam int SETTING_COUNT = 6;
    localparam int DIRECTED_ROWS = 16;
    localparam int unsigned TAIL_ORDER [10] = '{
        rv_isel_pkg::B_MEI, rv_isel_pkg::B_MSI, rv_isel_pkg::B_MTI, rv_isel_pkg::B_SEI,
        rv_isel_pkg::B_SSI, rv_isel_pkg::B_STI, rv_isel_pkg::B_SGEI, rv_isel_pkg::B_VSEI,
        rv_isel_pkg::B_VSSI, rv_isel_pkg::B_VSTI
    };

    typedef struct packed {
        rv_isel_pkg::t_in_word  word;
        bit                     typed;
        rv_isel_pkg::t_out_word want;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // privilege[1:0], virt_on[2], machine_ie[3], super_ie[4], vsuper_ie[5],
    // pending_bits[69:6], enable_bits[133:70], nmi_pending[134], zero[135]
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // taken[0], is_nmi[1], cause[9:2], bad_mode[10], zero[15:11]
    logic [15:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    // local copy of the register file
    logic [63:0] cfg_mdeleg = '0;
    logic [63:0] cfg_hdeleg = '0;
    logic        cfg_has_s = 1'b1;
    logic        cfg_has_h = 1'b0;
    logic        cfg_wide = 1'b1;
    logic [7:0]  cfg_nmi_code = '0;

    rv_isel_pkg::t_out_word expected_selections [$];
    t_row        directed_rows [DIRECTED_ROWS];
    int          mismatch_count = 0;
    int          words_checked = 0;
    int          nmi_seen = 0;
    int          bad_mode_seen = 0;
    int          irq_seen = 0;
    int          random_sent = 0;
    int          src_idle_pct = 0;
    int          dst_idle_pct = 0;
    int          quiet_cycles = 0;
    bit          stall_hold_on = 1'b0;
    int          stall_left = -1;

    riscv_interrupt_select_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    function automatic rv_isel_pkg::t_in_word stim(input logic [1:0] prv, input logic virt,
                                      input logic mie, input logic sie, input logic vsie,
                                      input logic [63:0] pend, input logic [63:0] en,
                                      input logic nmi);
        rv_isel_pkg::t_in_word w;
        w = '0;
        w.privilege    = prv;
        w.virt_on      = virt;
        w.machine_ie   = mie;
        w.super_ie     = sie;
        w.vsuper_ie    = vsie;
        w.pending_bits = pend;
        w.enable_bits  = en;
        w.nmi_pending  = nmi;
        return w;
    endfunction

    function automatic rv_isel_pkg::t_out_word selection(input logic taken, input logic nmi,
                                            input logic [7:0] cause, input logic bad);
        rv_isel_pkg::t_out_word r;
        r = '0;
        r.taken    = taken;
        r.is_nmi   = nmi;
        r.cause    = cause;
        r.bad_mode = bad;
        return r;
    endfunction

    function automatic rv_isel_pkg::t_out_word predict_selection(
        input rv_isel_pkg::t_in_word w
    );
        rv_isel_pkg::t_out_word r;
        logic [63:0] md;
        logic [63:0] both;
        logic [63:0] unmasked;
        logic [63:0] ready;
        logic        virt;
        int          top;
        r = '0;
        r.bad_mode = (w.privilege == rv_isel_pkg::PRV_BAD);
        if (w.nmi_pending) begin
            r.taken  = 1'b1;
            r.is_nmi = 1'b1;
            r.cause  = cfg_nmi_code;
            return r;
        end
        if (w.privilege == rv_isel_pkg::PRV_BAD) begin
            return r;
        end
        md       = cfg_has_s ? cfg_mdeleg : '0;
        both     = md & cfg_hdeleg;
        virt     = cfg_has_h && w.virt_on;
        unmasked = '0;
        if (w.privilege == rv_isel_pkg::PRV_M) begin
            if (w.machine_ie) unmasked = rv_isel_pkg::LOCAL_MASK | rv_isel_pkg::M_GROUP;
        end else if (virt) begin
            unmasked = ((w.privilege == rv_isel_pkg::PRV_S && w.super_ie) ? '1 : ~both)
                     & rv_isel_pkg::LOCAL_MASK;
            unmasked |= (w.vsuper_ie ? '1 : ~cfg_hdeleg) & rv_isel_pkg::VS_GROUP;
            unmasked |= (w.vsuper_ie ? '1 : ~both)
                      & (rv_isel_pkg::M_GROUP | rv_isel_pkg::S_GROUP);
        end else if (w.privilege == rv_isel_pkg::PRV_U) begin
            unmasked = rv_isel_pkg::LOCAL_MASK | rv_isel_pkg::M_GROUP | rv_isel_pkg::S_GROUP;
        end else begin
            unmasked = (w.super_ie ? '1 : ~md)
                     & (rv_isel_pkg::LOCAL_MASK | rv_isel_pkg::M_GROUP);
            if (w.super_ie) unmasked |= rv_isel_pkg::S_GROUP;
        end
        ready = w.pending_bits & w.enable_bits & unmasked;
        // locals high to low, narrow order goes no higher than local 15
        top = cfg_wide ? 63 : 31;
        for (int i = top; i >= int'(rv_isel_pkg::LOCAL_BASE); i--) begin
            if (ready[i]) begin
                r.taken = 1'b1;
                r.cause = 8'(i);
                return r;
            end
        end
        for (int k = 0; k < (cfg_wide ? 10 : 6); k++) begin
            if (ready[TAIL_ORDER[k]]) begin
                r.taken = 1'b1;
                r.cause = 8'(TAIL_ORDER[k]);
                return r;
            end
        end
        return r;
    endfunction

    function automatic rv_isel_pkg::t_in_word random_word();
        rv_isel_pkg::t_in_word w;
        int unsigned pick;
        w = '0;
        pick = $urandom_range(9);
        case (pick)
            0:       w.privilege = rv_isel_pkg::PRV_BAD;
            1, 2, 3: w.privilege = rv_isel_pkg::PRV_U;
            4, 5, 6: w.privilege = rv_isel_pkg::PRV_S;
            default: w.privilege = rv_isel_pkg::PRV_M;
        endcase
        w.virt_on     = 1'($urandom_range(1));
        w.machine_ie  = 1'($urandom_range(1));
        w.super_ie    = 1'($urandom_range(1));
        w.vsuper_ie   = 1'($urandom_range(1));
        w.nmi_pending = ($urandom_range(15) == 0);
        // shapes that let the lower-priority sources win now and then
        case ($urandom_range(3))
            0: begin
                w.pending_bits = wide_random();
                w.enable_bits  = wide_random();
            end
            1: begin
                w.pending_bits = wide_random() & 64'hFFFF;
                w.enable_bits  = wide_random();
            end
            2: begin
                w.pending_bits = (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
                w.enable_bits  = '1;
            end
            default: begin
                w.pending_bits = (wide_random() & 64'h1FFF) | (64'd1 << $urandom_range(63));
                w.enable_bits  = wide_random() | 64'h1FFF;
            end
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    // offer one word, record its expected selection once it is taken
    task automatic send_word(input rv_isel_pkg::t_in_word w, input bit typed,
                             input rv_isel_pkg::t_out_word want);
        rv_isel_pkg::t_out_word expect_now;
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        expect_now = typed ? want : predict_selection(w);
        expected_selections = {expected_selections, expect_now};
    endtask

    // leaves the bus selected; the caller releases it after its last write
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            rv_isel_pkg::REG_MDELEG: cfg_mdeleg   = value;
            rv_isel_pkg::REG_HDELEG: cfg_hdeleg   = value;
            rv_isel_pkg::REG_HAS_S:  cfg_has_s    = value[0];
            rv_isel_pkg::REG_HAS_H:  cfg_has_h    = value[0];
            rv_isel_pkg::REG_WIDE:   cfg_wide     = value[0];
            rv_isel_pkg::REG_NMI:    cfg_nmi_code = value[7:0];
            default: ;
        endcase
    endtask

    // registers only change once the pipeline has drained
    task automatic apply_setting(input logic [63:0] md, input logic [63:0] hd,
                                 input logic has_s, input logic has_h,
                                 input logic wide, input logic [7:0] nmi_code);
        s_axis_tvalid <= 1'b0;
        while (expected_selections.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(rv_isel_pkg::REG_MDELEG, md);
        write_reg(rv_isel_pkg::REG_HDELEG, hd);
        write_reg(rv_isel_pkg::REG_HAS_S, {63'd0, has_s});
        write_reg(rv_isel_pkg::REG_HAS_H, {63'd0, has_h});
        write_reg(rv_isel_pkg::REG_WIDE, {63'd0, wide});
        write_reg(rv_isel_pkg::REG_NMI, {56'd0, nmi_code});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (stall_hold_on && stall_left < 0) stall_left = 64;
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        rv_isel_pkg::t_out_word got;
        rv_isel_pkg::t_out_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = rv_isel_pkg::t_out_word'(m_axis_tdata);
            if (expected_selections.size() == 0) begin
                report_mismatch("word with nothing expected", 64'(got), '0);
            end else begin
                want = expected_selections.pop_front();
                if (got.taken !== want.taken)
                    report_mismatch("taken", 64'(got.taken), 64'(want.taken));
                if (got.is_nmi !== want.is_nmi)
                    report_mismatch("is_nmi", 64'(got.is_nmi), 64'(want.is_nmi));
                if (got.cause !== want.cause)
                    report_mismatch("cause", 64'(got.cause), 64'(want.cause));
                if (got.bad_mode !== want.bad_mode)
                    report_mismatch("bad_mode", 64'(got.bad_mode), 64'(want.bad_mode));
                words_checked++;
                if (want.is_nmi) nmi_seen++;
                else if (want.taken) irq_seen++;
                if (want.bad_mode) bad_mode_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: wide order, supervisor only, no delegation, nmi cause 0
        directed_rows = '{
            '{stim(rv_isel_pkg::PRV_M, 1'b0, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0), 1'b1,
              selection(1'b0, 1'b0, 8'd0, 1'b0)},
            '{stim(rv_isel_pkg::PRV_M, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b1), 1'b1,
              selection(1'b1, 1'b1, 8'd0, 1'b0)},
            '{stim(rv_isel_pkg::PRV_BAD, 1'b1, 1'b1, 1'b1, 1'b1, '1, '1, 1'b0), 1'b1,
              selection(1'b0, 1'b0, 8'd0, 1'b1)},
            '{stim(rv_isel_pkg::PRV_BAD, 1'b0, 1'b1, 1'b1, 1'b1, '1, '1, 1'b1), 1'b1,
              selection(1'b1, 1'b1, 8'd0, 1'b1)},
            '{stim(rv_isel_pkg::PRV_M, 1'b0, 1'b1, 1'b0, 1'b0, '1, '1, 1'b0), 1'b1,
              selection(1'b1, 1'b0, 8'd63, 1'b0)},
            '{stim(rv_isel_pkg::PRV_M, 1'b0, 1'b0, 1'b1, 1'b1, '1, '1, 1'b0), 1'b1,
              selection(1'b0, 1'b0, 8'd0, 1'b0)},
            '{stim(rv_isel_pkg::PRV_M, 1'b0, 1'b1, 1'b0, 1'b0, 64'hFFFF, '1, 1'b0), 1'b1,
              selection(1'b1, 1'b0, 8'd11, 1'b0)},
            '{stim(rv_isel_pkg::PRV_M, 1'b1, 1'b1, 1'b1, 1'b1, '1, '0, 1'b0), 1'b1,
              selection(1'b0, 1'b0, 8'd0, 1'b0)},
            '{stim(rv_isel_pkg::PRV_U, 1'b0, 1'b0, 1'b0, 1'b0,
                   rv_isel_pkg::S_GROUP | rv_isel_pkg::VS_GROUP | 64'h1000, '1, 1'b0),
              1'b0, '0},
            '{stim(rv_isel_pkg::PRV_S, 1'b0, 1'b0, 1'b0, 1'b0, rv_isel_pkg::S_GROUP, '1,
                   1'b0), 1'b0, '0},
            '{stim(rv_isel_pkg::PRV_S, 1'b0, 1'b0, 1'b1, 1'b0, 64'h22, '1, 1'b0), 1'b0, '0},
            // guest external never gets through
            '{stim(rv_isel_pkg::PRV_U, 1'b0, 1'b1, 1'b1, 1'b1, 64'h1000, '1, 1'b0), 1'b0, '0},
            // virtual supervisor sources outside virtualisation stay masked
            '{stim(rv_isel_pkg::PRV_U, 1'b1, 1'b1, 1'b1, 1'b1, rv_isel_pkg::VS_GROUP, '1,
                   1'b0), 1'b0, '0},
            '{stim(rv_isel_pkg::PRV_M, 1'b0, 1'b1, 1'b0, 1'b0, 64'h1_0000, '1, 1'b0),
              1'b0, '0},
            '{stim(rv_isel_pkg::PRV_U, 1'b0, 1'b0, 1'b0, 1'b0, 64'hA0, 64'hA0, 1'b0),
              1'b0, '0},
            '{stim(rv_isel_pkg::PRV_S, 1'b0, 1'b0, 1'b1, 1'b0, 64'h8000_0000_0000_0000, '1,
                   1'b0), 1'b0, '0}
        };
        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].want);
        end

        for (int setting = 0; setting < SETTING_COUNT; setting++) begin
            case (setting)
                0: ;
                1: apply_setting('1, '1, 1'b1, 1'b1, 1'b1, 8'hFF);
                2: apply_setting(wide_random(), wide_random(), 1'b1, 1'b1, 1'b0,
                                 8'($urandom));
                3: apply_setting(wide_random(), wide_random(), 1'b0, 1'b1, 1'b1,
                                 8'($urandom));
                4: apply_setting('0, '1, 1'b1, 1'b0, 1'b0, 8'h5A);
                default: apply_setting(wide_random(), wide_random(), 1'($urandom_range(1)),
                                       1'b1, 1'($urandom_range(1)), 8'($urandom));
            endcase
            repeat (RANDOM_PER_SETTING) begin
                if (random_sent < 267) begin
                    src_idle_pct = 33;
                    dst_idle_pct = 83;
                end else if (random_sent < 534) begin
                    src_idle_pct = 83;
                    dst_idle_pct = 33;
                end else begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
                // long back-pressure while words keep coming
                if (random_sent == 600) stall_hold_on = 1'b1;
                send_word(random_word(), 1'b0, '0);
                random_sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_selections.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("checked %0d words (%0d from the directed table) over %0d register settings",
                 words_checked, DIRECTED_ROWS, SETTING_COUNT);
        $display("nmi %0d, invalid privilege %0d, maskable interrupts selected %0d",
                 nmi_seen, bad_mode_seen, irq_seen);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
